/* hw/rtl/isl_pkg.sv */
package isl_pkg;

  // field widths fixed by the interface
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned ENTRY_W    = 8;
  localparam int unsigned COUNT_OUT_W = 9;

  localparam int unsigned LOG_DEPTH_DEF = 256;
  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd60000;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } isl_op_e;

  // saturate a signed tenths value into one unsigned byte
  function automatic logic [ENTRY_W-1:0] clamp_tenths(input logic signed [TEMP_W-1:0] t);
    logic [ENTRY_W-1:0] r;
    if (t > $signed({{(TEMP_W-ENTRY_W){1'b0}}, ENTRY_MAX})) begin
      r = ENTRY_MAX;
    end else if (t < 0) begin
      r = '0;
    end else begin
      r = t[ENTRY_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/interval_sample_logger.sv */
// channel   direction  handshake                   payload
// in        input      in_valid_i / in_ready_o     operation, current_time_ms,
//                                                  temperature_tenths, read_index
// out       output     out_valid_o / out_ready_i   entry_value, entry_present,
//                                                  sample_logged, entry_count
// cfg       input      cfg_we_i (no wait)          cfg_wdata_i -> log_interval_ms
//
// one transaction per cycle sustained while out_ready_i stays high; the input register
//   and the result register sit around one multiply-compare
// the log memory is read with a registered read port in the same pass
// rst_ni clears control state, the fill count, the start time and the interval
//   register (to 60000); log entries are not cleared, the fill count masks them
// a stalled output holds the pipe: the input register keeps its transaction and
//   in_ready_o drops only when both registers are full and out_ready_i is low
module interval_sample_logger #(
  parameter int unsigned LOG_DEPTH = isl_pkg::LOG_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [isl_pkg::TIME_W-1:0]         cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [isl_pkg::OP_W-1:0]           operation_i,
  input  logic [isl_pkg::TIME_W-1:0]         current_time_ms_i,
  input  logic signed [isl_pkg::TEMP_W-1:0]  temperature_tenths_i,
  input  logic [isl_pkg::INDEX_W-1:0]        read_index_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [isl_pkg::ENTRY_W-1:0]        entry_value_o,
  output logic                               entry_present_o,
  output logic                               sample_logged_o,
  output logic [isl_pkg::COUNT_OUT_W-1:0]    entry_count_o
);

  // address, count and product widths all follow the log depth
  localparam int unsigned AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(LOG_DEPTH + 1);
  localparam int unsigned PW   = CW + isl_pkg::TIME_W;
  localparam int unsigned CMPW = CW + isl_pkg::INDEX_W;

  // configuration register
  logic [isl_pkg::TIME_W-1:0] interval_q;

  // input register
  logic                              s1_valid_q;
  logic [isl_pkg::OP_W-1:0]          s1_op_q;
  logic [isl_pkg::TIME_W-1:0]        s1_time_q;
  logic signed [isl_pkg::TEMP_W-1:0] s1_temp_q;
  logic [isl_pkg::INDEX_W-1:0]       s1_idx_q;

  // logger state
  logic [isl_pkg::TIME_W-1:0] start_q, start_d;
  logic [CW-1:0]              count_q, count_d;

  // result register
  logic out_valid_q;
  logic present_q, present_d;
  logic logged_q, logged_d;
  logic [isl_pkg::ENTRY_W-1:0] rd_data;

  // pass logic
  logic                       adv;
  logic [isl_pkg::TIME_W-1:0] start_eff;
  logic [isl_pkg::TIME_W-1:0] elapsed;
  logic [PW-1:0]              due;
  logic                       full;
  logic                       wr_en;

  // the input register moves on whenever the result register is free or drained
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= isl_pkg::INTERVAL_RESET;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q   <= operation_i;
      s1_time_q <= current_time_ms_i;
      s1_temp_q <= temperature_tenths_i;
      s1_idx_q  <= read_index_i;
    end
  end

  // a start of zero means not yet latched
  assign start_eff = (start_q == '0) ? s1_time_q : start_q;
  // elapsed time wraps modulo 2^32
  assign elapsed   = s1_time_q - start_eff;
  // exact product, wide enough that it never wraps
  assign due       = PW'(count_q) * PW'(interval_q);
  assign full      = (count_q >= CW'(LOG_DEPTH));

  always_comb begin
    start_d   = start_q;
    count_d   = count_q;
    present_d = 1'b0;
    logged_d  = 1'b0;
    wr_en     = 1'b0;
    case (s1_op_q)
      isl_pkg::OP_UPDATE: begin
        start_d = start_eff;
        if ((PW'(elapsed) >= due) && !full) begin
          wr_en    = 1'b1;
          logged_d = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      isl_pkg::OP_READ: begin
        // index below the count is always inside the memory
        present_d = (CMPW'(s1_idx_q) < CMPW'(count_q));
      end
      isl_pkg::OP_CLEAR: begin
        start_d = '0;
        count_d = '0;
      end
      default: begin
        // unused code: state untouched, result carries the count only
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      present_q   <= 1'b0;
      logged_q    <= 1'b0;
    end else begin
      if (adv) begin
        start_q   <= start_d;
        count_q   <= count_d;
        present_q <= present_d;
        logged_q  <= logged_d;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // log memory, read data lands together with the result register
  isl_store #(
    .DEPTH (LOG_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (adv && wr_en),
    .wr_addr_i (AW'(count_q)),
    .wr_data_i (isl_pkg::clamp_tenths(s1_temp_q)),
    .rd_en_i   (adv),
    .rd_addr_i (AW'(s1_idx_q)),
    .rd_data_o (rd_data)
  );

  assign out_valid_o     = out_valid_q;
  assign entry_value_o   = present_q ? rd_data : '0;
  assign entry_present_o = present_q;
  assign sample_logged_o = logged_q;
  // the count register only moves together with the result register
  assign entry_count_o   = isl_pkg::COUNT_OUT_W'(count_q);

  // a logged sample bumps the count by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && wr_en) |=> (count_q == $past(count_q) + 1'b1))
    else $error("count did not follow a logged sample");

  // the fill count never passes the log depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LOG_DEPTH))
    else $error("count beyond log depth");

  // a clear empties the log and forgets the start time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (s1_op_q == isl_pkg::OP_CLEAR)) |=> ((count_q == '0) && (start_q == '0)))
    else $error("clear left state behind");

  // a read result never claims a logged sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && present_q) |-> !logged_q)
    else $error("read and log flags both set");

  // state holds while a result waits to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(count_q) && $stable(start_q)))
    else $error("state moved under a stalled result");

endmodule

/* hw/rtl/isl_store.sv */
module isl_store #(
  parameter int unsigned DEPTH = isl_pkg::LOG_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [isl_pkg::ENTRY_W-1:0]    wr_data_i,
  input  logic                           rd_en_i,
  input  logic [AW-1:0]                  rd_addr_i,
  output logic [isl_pkg::ENTRY_W-1:0]    rd_data_o
);

  // no reset: entries are only read below the fill count
  logic [isl_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [isl_pkg::ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
